// File: src/tcps_pkg.sv
// Shared types and constants for three_channel_peak_stats.
// No dependencies.
package tcps_pkg;

    localparam int DEPTH_DEF       = 128;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;

    localparam logic [11:0] THRESH_RST   = 12'd28;
    localparam logic [15:0] DEBOUNCE_RST = 16'd200;
    localparam logic [11:0] CEILING_RST  = 12'd180;

    localparam logic [1:0] REG_THRESH   = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE = 2'd1;
    localparam logic [1:0] REG_CEILING  = 2'd2;

    // divider request / status between top and divider
    typedef struct packed {
        logic        start;
        logic [40:0] dividend;
        logic [8:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [40:0] quotient;
    } div_stat_t;

    // one result word, field by field as on the m_ ports
    typedef struct packed {
        logic [1:0]  peak_channel;
        logic [6:0]  peak_count;
        logic [20:0] sample_sum;
        logic [8:0]  nonzero_count;
        logic [11:0] highest_raw;
        logic [11:0] lowest_raw;
        logic [13:0] average_raw;
        logic [40:0] interval_sum;
        logic [8:0]  interval_pairs;
        logic [31:0] average_interval;
        logic [31:0] elapsed_ms;
    } stats_t;

endpackage

// File: src/tcps_div.sv
// Restoring divider, one quotient bit per cycle, 41-bit by 9-bit.
// Depends on tcps_pkg.
module tcps_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  tcps_pkg::div_req_t req,
    output tcps_pkg::div_stat_t stat
);
    logic [40:0] quo_reg, quo_next;
    logic [9:0]  rem_reg, rem_next;
    logic [8:0]  dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [9:0]  trial;
    logic [10:0] diff;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[8:0], quo_reg[40]};
        diff      = {1'b0, trial} - {2'b00, dvs_reg};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 6'd41;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[10]) begin
                rem_next = diff[9:0];
                quo_next = {quo_reg[39:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[39:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;
endmodule

// File: src/three_channel_peak_stats.sv
// Top level of the three-channel peak statistics block.
// Depends on tcps_pkg and tcps_div.
//
// Use: words on the s_ channel carry a command (start, sample, stop) with
// three raw readings and a ms timestamp. Start clears the capture and
// records its time; sample stores one row while capturing; stop with at
// least one stored row produces one word on the m_ channel with the peak
// channel, debounced peak count, sums, extremes, averages and elapsed time.
// Start and sample words are taken while idle, one word per cycle; s_ready
// is low from a stop that starts an analysis until its result is taken. A
// full store wraps the row count to zero, so its stop emits nothing. A
// stop walks the store three times: pass 1 finds the peak channel and
// pass 2 counts crossings, one memory read per cycle; pass 3 walks every
// sample, one channel per cycle; then two divisions run on the shared
// divider. The single read port of the sample memory and the bit-serial
// divider bound how long a stop takes. Reset clears control state and the
// registers to their defaults; the sample memory is not cleared, only rows
// of the current capture are read. A result waits in the output register
// while m_ready is low; the block takes no new word until it is taken.
// Registers: 0x0 peak_threshold, 0x4 debounce_ms, 0x8 lowest_ceiling.
module three_channel_peak_stats #(
    parameter int DEPTH = tcps_pkg::DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [11:0] s_sample_a,
    input  logic [11:0] s_sample_b,
    input  logic [11:0] s_sample_c,
    input  logic [31:0] s_time_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_peak_channel,
    output logic [6:0]  m_peak_count,
    output logic [20:0] m_sample_sum,
    output logic [8:0]  m_nonzero_count,
    output logic [11:0] m_highest_raw,
    output logic [11:0] m_lowest_raw,
    output logic [13:0] m_average_raw,
    output logic [40:0] m_interval_sum,
    output logic [8:0]  m_interval_pairs,
    output logic [31:0] m_average_interval,
    output logic [31:0] m_elapsed_ms
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SB = tcps_pkg::SAMPLE_BITS_DEF;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_P1    = 9'b000000010,
        ST_P2    = 9'b000000100,
        ST_P3    = 9'b000001000,
        ST_DIV1  = 9'b000010000,
        ST_DIV1W = 9'b000100000,
        ST_DIV2  = 9'b001000000,
        ST_DIV2W = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    // ---------------- configuration ----------------
    logic [11:0] thresh_reg;
    logic [15:0] debounce_reg;
    logic [11:0] ceiling_reg;
    logic        cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg   <= tcps_pkg::THRESH_RST;
            debounce_reg <= tcps_pkg::DEBOUNCE_RST;
            ceiling_reg  <= tcps_pkg::CEILING_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                tcps_pkg::REG_THRESH:   thresh_reg   <= pwdata[11:0];
                tcps_pkg::REG_DEBOUNCE: debounce_reg <= pwdata[15:0];
                tcps_pkg::REG_CEILING:  ceiling_reg  <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            tcps_pkg::REG_THRESH:   prdata = {20'd0, thresh_reg};
            tcps_pkg::REG_DEBOUNCE: prdata = {16'd0, debounce_reg};
            tcps_pkg::REG_CEILING:  prdata = {20'd0, ceiling_reg};
            default:                prdata = '0;
        endcase
    end

    // ---------------- sample memory ----------------
    // one row, MSB first: time, c, b, a
    logic [3*SB+31:0] mem [DEPTH];
    logic [3*SB+31:0] rd_reg;
    logic [AW-1:0]    raddr;
    logic             mem_we;
    logic             rd_hold;

    // ---------------- control state ----------------
    state_t      state_reg, state_next;
    logic [AW:0] fill_reg, fill_next;      // wraps to zero on reaching DEPTH
    logic        cap_reg, cap_next;
    logic [31:0] start_reg, start_next;
    logic [AW:0] n_reg, n_next;            // rows to analyze
    logic [AW:0] idx_reg, idx_next;        // read address counter
    logic [AW:0] pos_reg, pos_next;        // index of row in rd_reg
    logic        rv_reg, rv_next;          // rd_reg holds a row
    logic [1:0]  k_reg, k_next;            // channel within row (pass 3)

    // analysis accumulators
    logic [1:0]  ch_reg, ch_next;
    logic [SB-1:0] best_reg, best_next;
    logic [6:0]  peaks_reg, peaks_next;
    logic [31:0] lastpk_reg, lastpk_next;
    logic        prevlo_reg, prevlo_next;  // previous sel sample below threshold
    logic [20:0] sum_reg, sum_next;
    logic [8:0]  nz_reg, nz_next;
    logic [11:0] low_reg, low_next;
    logic [40:0] isum_reg, isum_next;
    logic [8:0]  pairs_reg, pairs_next;
    logic [31:0] prevt_reg, prevt_next;
    logic        havep_reg, havep_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic [13:0] avg_reg, avg_next;
    logic [31:0] avgi_reg, avgi_next;

    tcps_pkg::div_req_t  div_req;
    tcps_pkg::div_stat_t div_stat;

    tcps_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .stat    (div_stat)
    );

    // row fields
    logic [SB-1:0] ra, rb, rc, rsel, rv;
    logic [31:0]   rt;
    logic [31:0]   gap;
    logic [21:0]   sum_w;
    logic [41:0]   isum_w;
    logic [SB:0]   thr_x;
    logic          sel_hi;

    assign ra = rd_reg[SB-1:0];
    assign rb = rd_reg[2*SB-1:SB];
    assign rc = rd_reg[3*SB-1:2*SB];
    assign rt = rd_reg[3*SB+31:3*SB];
    assign rsel = (ch_reg == 2'd1) ? ra : (ch_reg == 2'd2) ? rb : rc;
    assign rv   = (k_reg == 2'd0) ? ra : (k_reg == 2'd1) ? rb : rc;
    assign gap  = rt - prevt_reg;
    assign thr_x  = {1'b0, thresh_reg} << 0;
    assign sel_hi = {1'b0, rsel} >= thr_x;

    assign s_ready = (state_reg == ST_IDLE);
    assign raddr   = idx_reg[AW-1:0];
    assign mem_we  = s_valid && s_ready && s_command == tcps_pkg::CMD_SAMPLE && cap_reg
                     && fill_reg < (AW+1)'(DEPTH);
    // pass 3 keeps the row for its three channels
    assign rd_hold = (state_reg == ST_P3) && rv_reg && (k_reg != 2'd2);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[fill_reg[AW-1:0]] <= {s_time_ms, s_sample_c[SB-1:0],
                                      s_sample_b[SB-1:0], s_sample_a[SB-1:0]};
        end
        if (!rd_hold) rd_reg <= mem[raddr];
    end

    always_comb begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        cap_next    = cap_reg;
        start_next  = start_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        rv_next     = 1'b0;
        k_next      = k_reg;
        ch_next     = ch_reg;
        best_next   = best_reg;
        peaks_next  = peaks_reg;
        lastpk_next = lastpk_reg;
        prevlo_next = prevlo_reg;
        sum_next    = sum_reg;
        nz_next     = nz_reg;
        low_next    = low_reg;
        isum_next   = isum_reg;
        pairs_next  = pairs_reg;
        prevt_next  = prevt_reg;
        havep_next  = havep_reg;
        elapsed_next = elapsed_reg;
        avg_next    = avg_reg;
        avgi_next   = avgi_reg;
        div_req     = '0;
        sum_w       = '0;
        isum_w      = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_command)
                        tcps_pkg::CMD_START: begin
                            cap_next   = 1'b1;
                            fill_next  = '0;
                            start_next = s_time_ms;
                        end
                        tcps_pkg::CMD_SAMPLE: begin
                            if (mem_we) begin
                                fill_next = fill_reg + 1'b1;
                                if (fill_reg + 1'b1 >= (AW+1)'(DEPTH)) fill_next = '0;
                            end
                        end
                        tcps_pkg::CMD_STOP: begin
                            cap_next  = 1'b0;
                            fill_next = '0;
                            if (fill_reg != '0) begin
                                n_next       = fill_reg;
                                elapsed_next = s_time_ms - start_reg;
                                idx_next     = '0;
                                pos_next     = '0;
                                ch_next      = '0;
                                best_next    = '0;
                                state_next   = ST_P1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // pass 1: peak channel, one row per cycle
            ST_P1: begin
                if (idx_reg < n_reg) begin
                    idx_next = idx_reg + 1'b1;
                    rv_next  = 1'b1;
                end
                if (rv_reg) begin
                    pos_next = pos_reg + 1'b1;
                    if (ra > best_next) begin best_next = ra; ch_next = 2'd1; end
                    if (rb > best_next) begin best_next = rb; ch_next = 2'd2; end
                    if (rc > best_next) begin best_next = rc; ch_next = 2'd3; end
                    if (pos_reg + 1'b1 == n_reg) begin
                        state_next  = ST_P2;
                        idx_next    = '0;
                        pos_next    = '0;
                        rv_next     = 1'b0;
                        peaks_next  = '0;
                        lastpk_next = '0;
                    end
                end
            end
            // pass 2: debounced rising crossings on the peak channel
            ST_P2: begin
                if (idx_reg < n_reg) begin
                    idx_next = idx_reg + 1'b1;
                    rv_next  = 1'b1;
                end
                if (rv_reg) begin
                    pos_next    = pos_reg + 1'b1;
                    prevlo_next = !sel_hi;
                    if (pos_reg != '0 && sel_hi && prevlo_reg
                        && (rt - lastpk_reg) > {16'd0, debounce_reg}) begin
                        if (peaks_reg != 7'h7f) peaks_next = peaks_reg + 1'b1;
                        lastpk_next = rt;
                    end
                    if (pos_reg + 1'b1 == n_reg) begin
                        state_next = ST_P3;
                        idx_next   = '0;
                        pos_next   = '0;
                        rv_next    = 1'b0;
                        k_next     = '0;
                        sum_next   = '0;
                        nz_next    = '0;
                        low_next   = ceiling_reg;
                        isum_next  = '0;
                        pairs_next = '0;
                        havep_next = 1'b0;
                        best_next  = '0;
                    end
                end
            end
            // pass 3: one channel of one row per cycle; row held in rd_reg
            ST_P3: begin
                rv_next = rv_reg;
                if (!rv_reg) begin
                    if (idx_reg < n_reg) begin
                        idx_next = idx_reg + 1'b1;
                        rv_next  = 1'b1;
                    end
                end else begin
                    sum_w = {1'b0, sum_reg} + 22'(rv);
                    sum_next = sum_w[21] ? 21'h1fffff : sum_w[20:0];
                    if (rv > best_reg) best_next = rv;
                    if (rv != '0) begin
                        if (nz_reg != 9'h1ff) nz_next = nz_reg + 1'b1;
                        if (havep_reg) begin
                            isum_w    = {1'b0, isum_reg} + 42'(gap);
                            isum_next = isum_w[41] ? {41{1'b1}} : isum_w[40:0];
                            if (pairs_reg != 9'h1ff) pairs_next = pairs_reg + 1'b1;
                        end
                        prevt_next = rt;
                        havep_next = 1'b1;
                        if ({1'b0, rv} < {1'b0, low_reg}) low_next = 12'(rv);
                    end
                    k_next = k_reg + 1'b1;
                    if (k_reg == 2'd2) begin
                        k_next   = '0;
                        pos_next = pos_reg + 1'b1;
                        rv_next  = 1'b0;
                        if (idx_reg < n_reg) begin
                            idx_next = idx_reg + 1'b1;
                            rv_next  = 1'b1;
                        end
                        if (pos_reg + 1'b1 == n_reg) state_next = ST_DIV1;
                    end
                end
            end
            ST_DIV1: begin
                if (nz_reg == '0) low_next = '0;
                div_req.start    = 1'b1;
                div_req.dividend = {20'd0, sum_reg};
                div_req.divisor  = (nz_reg == '0) ? 9'd1 : nz_reg;
                state_next       = ST_DIV1W;
            end
            ST_DIV1W: begin
                if (div_stat.done) begin
                    avg_next = (nz_reg == '0) ? 14'd0
                             : (div_stat.quotient > 41'h3fff) ? 14'h3fff
                             : div_stat.quotient[13:0];
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2: begin
                div_req.start    = 1'b1;
                div_req.dividend = isum_reg;
                div_req.divisor  = (pairs_reg == '0) ? 9'd1 : pairs_reg;
                state_next       = ST_DIV2W;
            end
            ST_DIV2W: begin
                if (div_stat.done) begin
                    avgi_next = (pairs_reg == '0) ? 32'd0
                              : (div_stat.quotient > 41'hffffffff) ? 32'hffffffff
                              : div_stat.quotient[31:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            cap_reg   <= 1'b0;
            start_reg <= '0;
            rv_reg    <= 1'b0;
            idx_reg   <= '0;
            pos_reg   <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            cap_reg   <= cap_next;
            start_reg <= start_next;
            rv_reg    <= rv_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
            k_reg     <= k_next;
        end
        n_reg       <= n_next;
        ch_reg      <= ch_next;
        best_reg    <= best_next;
        peaks_reg   <= peaks_next;
        lastpk_reg  <= lastpk_next;
        prevlo_reg  <= prevlo_next;
        sum_reg     <= sum_next;
        nz_reg      <= nz_next;
        low_reg     <= low_next;
        isum_reg    <= isum_next;
        pairs_reg   <= pairs_next;
        prevt_reg   <= prevt_next;
        havep_reg   <= havep_next;
        elapsed_reg <= elapsed_next;
        avg_reg     <= avg_next;
        avgi_reg    <= avgi_next;
    end

    assign m_valid            = (state_reg == ST_OUT);
    assign m_peak_channel     = ch_reg;
    assign m_peak_count       = peaks_reg;
    assign m_sample_sum       = sum_reg;
    assign m_nonzero_count    = nz_reg;
    assign m_highest_raw      = 12'(best_reg);
    assign m_lowest_raw       = low_reg;
    assign m_average_raw      = avg_reg;
    assign m_interval_sum     = isum_reg;
    assign m_interval_pairs   = pairs_reg;
    assign m_average_interval = avgi_reg;
    assign m_elapsed_ms       = elapsed_reg;
endmodule

// File: src/tcps_checker.sv
// Port-level checks for three_channel_peak_stats, bound to the top level.
// Depends on three_channel_peak_stats ports only.
module tcps_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [8:0]  m_nonzero_count,
    input logic [11:0] m_lowest_raw,
    input logic [13:0] m_average_raw,
    input logic [8:0]  m_interval_pairs,
    input logic [31:0] m_average_interval
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted while a result waits");
    a_zero_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_nonzero_count == '0 |-> m_lowest_raw == '0 && m_average_raw == '0)
        else $error("empty stats not zero");
    a_zero_pairs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_interval_pairs == '0 |-> m_average_interval == '0)
        else $error("interval average without pairs");
endmodule

bind three_channel_peak_stats tcps_checker u_tcps_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_valid            (s_valid),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_nonzero_count    (m_nonzero_count),
    .m_lowest_raw       (m_lowest_raw),
    .m_average_raw      (m_average_raw),
    .m_interval_pairs   (m_interval_pairs),
    .m_average_interval (m_average_interval)
);

// File: sim/tcps_scoreboard.sv
// Scoreboard for three_channel_peak_stats: capture model and result check.
// Depends on tcps_pkg.
`timescale 1ns / 100ps

class tcps_scoreboard;
    logic [11:0] peak_threshold;
    logic [15:0] debounce_ms;
    logic [11:0] lowest_ceiling;

    logic [11:0] row_a[128];
    logic [11:0] row_b[128];
    logic [11:0] row_c[128];
    logic [31:0] row_time[128];
    int          fill;
    bit          capturing;
    logic [31:0] start_time;

    tcps_pkg::stats_t pending_stats[$];
    int     mismatches;

    function new();
        peak_threshold = tcps_pkg::THRESH_RST;
        debounce_ms    = tcps_pkg::DEBOUNCE_RST;
        lowest_ceiling = tcps_pkg::CEILING_RST;
        fill = 0;
        capturing = 0;
        start_time = 0;
        mismatches = 0;
    endfunction

    function automatic tcps_pkg::stats_t analyze(int n, logic [31:0] now);
        tcps_pkg::stats_t r;
        logic [11:0] best, v, prev_v, cur_v;
        logic [1:0]  ch;
        logic [31:0] last_peak, prev_t, gap;
        longint      peaks, total, nz, pairs, isum;
        logic [11:0] hi, lo;
        bit          have_prev;
        best = 0; ch = 0; last_peak = 0; prev_t = 0; have_prev = 0;
        peaks = 0; total = 0; nz = 0; pairs = 0; isum = 0;
        hi = 0; lo = lowest_ceiling;
        for (int i = 0; i < n; i++) begin
            if (row_a[i] > best) begin best = row_a[i]; ch = 1; end
            if (row_b[i] > best) begin best = row_b[i]; ch = 2; end
            if (row_c[i] > best) begin best = row_c[i]; ch = 3; end
        end
        for (int i = 1; i < n; i++) begin
            cur_v  = (ch == 1) ? row_a[i] : (ch == 2) ? row_b[i] : row_c[i];
            prev_v = (ch == 1) ? row_a[i-1] : (ch == 2) ? row_b[i-1] : row_c[i-1];
            if (cur_v >= peak_threshold && prev_v < peak_threshold &&
                    (row_time[i] - last_peak) > {16'd0, debounce_ms}) begin
                peaks++;
                last_peak = row_time[i];
            end
        end
        for (int i = 0; i < n; i++) begin
            for (int k = 0; k < 3; k++) begin
                v = (k == 0) ? row_a[i] : (k == 1) ? row_b[i] : row_c[i];
                total += v;
                if (v != 0) begin
                    nz++;
                    if (have_prev) begin
                        gap = row_time[i] - prev_t;   // wraps at 32 bits
                        isum += gap;
                        pairs++;
                    end
                    prev_t = row_time[i];
                    have_prev = 1;
                    if (v < lo) lo = v;
                end
                if (v > hi) hi = v;
            end
        end
        if (nz == 0) lo = 0;
        r.peak_channel     = ch;
        r.peak_count       = (peaks > 127) ? 7'h7f : peaks[6:0];
        r.sample_sum       = total[20:0];
        r.nonzero_count    = nz[8:0];
        r.highest_raw      = hi;
        r.lowest_raw       = lo;
        r.average_raw      = nz ? 14'(total / nz) : 14'd0;
        r.interval_sum     = isum[40:0];
        r.interval_pairs   = pairs[8:0];
        r.average_interval = pairs ? 32'(isum / pairs) : 32'd0;
        r.elapsed_ms       = now - start_time;
        return r;
    endfunction

    function void note_word(logic [1:0] cmd, logic [11:0] a, logic [11:0] b,
                            logic [11:0] c, logic [31:0] t);
        case (cmd)
            tcps_pkg::CMD_START: begin
                capturing = 1; fill = 0; start_time = t;
            end
            tcps_pkg::CMD_SAMPLE: begin
                if (capturing) begin
                    row_a[fill] = a; row_b[fill] = b; row_c[fill] = c;
                    row_time[fill] = t;
                    fill = (fill + 1) % 128;
                end
            end
            tcps_pkg::CMD_STOP: begin
                capturing = 0;
                if (fill != 0) pending_stats.push_back(analyze(fill, t));
                fill = 0;
            end
            default: ;
        endcase
    endfunction

    function void check_result(tcps_pkg::stats_t got);
        tcps_pkg::stats_t want;
        if (pending_stats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected result word");
            return;
        end
        want = pending_stats.pop_front();
        if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result mismatch\n  exp %p\n  got %p", want, got);
        end
    endfunction
endclass

// File: sim/tb_top.sv
// Testbench top for three_channel_peak_stats: random traffic, APB setup, checks.
// Depends on tcps_pkg, tcps_scoreboard.sv and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = 0;
    logic [31:0] pwdata = 0, prdata;
    logic        pready;
    logic        s_valid = 0, s_ready;
    logic [1:0]  s_command = 0;
    logic [11:0] s_sample_a = 0, s_sample_b = 0, s_sample_c = 0;
    logic [31:0] s_time_ms = 0;
    logic        m_valid, m_ready = 0;
    tcps_pkg::stats_t got;

    tcps_scoreboard stats_board = new();
    longint cycle_count = 0;
    int     sent_in_burst = 0, burst_len = 4;
    logic [31:0] clock_ms = 0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    three_channel_peak_stats DUT (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
        .pready, .s_valid, .s_ready, .s_command, .s_sample_a, .s_sample_b,
        .s_sample_c, .s_time_ms, .m_valid, .m_ready,
        .m_peak_channel(got.peak_channel), .m_peak_count(got.peak_count),
        .m_sample_sum(got.sample_sum), .m_nonzero_count(got.nonzero_count),
        .m_highest_raw(got.highest_raw), .m_lowest_raw(got.lowest_raw),
        .m_average_raw(got.average_raw), .m_interval_sum(got.interval_sum),
        .m_interval_pairs(got.interval_pairs),
        .m_average_interval(got.average_interval), .m_elapsed_ms(got.elapsed_ms)
    );

    // Sample both handshakes at the rising edge; the model sees each accepted word.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && s_valid && s_ready)
            stats_board.note_word(s_command, s_sample_a, s_sample_b, s_sample_c,
                                  s_time_ms);
        if (aresetn && m_valid && m_ready) stats_board.check_result(got);
    end

    // Receiver stall pattern: long ready runs, then short and long stalls.
    always @(negedge aclk) begin
        case (cycle_count[9:8])
            2'd0:    m_ready <= 1'b1;
            2'd1:    m_ready <= ($urandom_range(0, 3) != 0);
            2'd2:    m_ready <= cycle_count[3];
            default: m_ready <= ($urandom_range(0, 1) == 0);
        endcase
    end

    // Watchdog: a run that has not finished by the cycle limit is a mismatch.
    always @(posedge aclk) begin
        if (cycle_count > 2_000_000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // APB write: setup cycle, then access cycle; pready is tied high.
    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        @(negedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= value;
        @(negedge aclk);
        penable <= 1;
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            tcps_pkg::REG_THRESH:   stats_board.peak_threshold = value[11:0];
            tcps_pkg::REG_DEBOUNCE: stats_board.debounce_ms    = value[15:0];
            default:                stats_board.lowest_ceiling = value[11:0];
        endcase
    endtask

    // One word on s_: bursty sender, random gaps between bursts.
    // Valid stays high into the next word of a burst; gaps and drain drop it.
    task automatic send_word(logic [1:0] cmd, logic [11:0] a, logic [11:0] b,
                             logic [11:0] c, logic [31:0] t);
        if (sent_in_burst >= burst_len) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            sent_in_burst = 0;
            burst_len = $urandom_range(1, 16);
        end
        s_valid <= 1; s_command <= cmd;
        s_sample_a <= a; s_sample_b <= b; s_sample_c <= c; s_time_ms <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        sent_in_burst++;
    endtask

    // Readings around the threshold, zeros and full-scale values.
    function automatic logic [11:0] rand_reading();
        case ($urandom_range(0, 5))
            0:       return 12'd0;
            1:       return 12'hfff;
            2:       return 12'($urandom_range(0, 60));
            default: return 12'($urandom());
        endcase
    endfunction

    task automatic sample_word();
        clock_ms = clock_ms + $urandom_range(0, 400);
        send_word(tcps_pkg::CMD_SAMPLE, rand_reading(), rand_reading(), rand_reading(),
                  clock_ms);
    endtask

    // Capture of n rows, then a stop.
    task automatic capture(int n);
        clock_ms = $urandom();
        send_word(tcps_pkg::CMD_START, 12'($urandom()), 12'($urandom()),
                  12'($urandom()), clock_ms);
        repeat (n) sample_word();
        if ($urandom_range(0, 9) == 0) clock_ms = $urandom();
        send_word(tcps_pkg::CMD_STOP, '0, '0, '0, clock_ms);
    endtask

    // Idle between phases: drain results, then cover the tail of a silent stop.
    task automatic drain();
        s_valid <= 0;
        while (stats_board.pending_stats.size() != 0) @(negedge aclk);
        repeat (800) @(negedge aclk);
    endtask

    initial begin
        int words;
        int n;
        repeat (11) @(negedge aclk);
        aresetn <= 1;

        // Directed: defaults, idle samples, unused code, empty stop, extremes.
        send_word(tcps_pkg::CMD_SAMPLE, 12'hfff, 12'hfff, 12'hfff, 32'hffff_ffff);
        send_word(tcps_pkg::CMD_STOP, '0, '0, '0, '0);
        send_word(2'd3, 12'hfff, '0, 12'hfff, 32'h5555_aaaa);
        send_word(tcps_pkg::CMD_START, '0, '0, '0, 32'hffff_fff0);
        send_word(tcps_pkg::CMD_SAMPLE, '0, '0, '0, '0);
        send_word(tcps_pkg::CMD_SAMPLE, '0, '0, '0, 32'haaaa_5555);
        send_word(tcps_pkg::CMD_STOP, '0, '0, '0, 32'h10);          // all-zero capture
        send_word(tcps_pkg::CMD_START, '0, '0, '0, 32'd100);
        send_word(tcps_pkg::CMD_START, '0, '0, '0, 32'd200);        // restart while capturing
        send_word(tcps_pkg::CMD_SAMPLE, 12'd5, 12'd5, 12'd5, '0);   // tie: channel a wins
        send_word(tcps_pkg::CMD_SAMPLE, 12'hfff, 12'hfff, 12'd1, 32'd500);
        send_word(tcps_pkg::CMD_SAMPLE, 12'd0, 12'd30, 12'hfff, 32'hffff_ffff);
        send_word(tcps_pkg::CMD_SAMPLE, 12'd40, 12'd0, 12'd0, 32'd900);
        send_word(tcps_pkg::CMD_STOP, '0, '0, '0, 32'd50);
        send_word(tcps_pkg::CMD_START, '0, '0, '0, '0);
        send_word(tcps_pkg::CMD_SAMPLE, 12'd7, '0, '0, '0);
        send_word(tcps_pkg::CMD_STOP, '0, '0, '0, '0);              // single row
        drain();

        // Full store wraps the index to zero: stop emits nothing.
        capture(128);
        drain();
        capture(127);
        drain();

        // Register settings, extremes included.
        reg_write(tcps_pkg::REG_THRESH, 32'd0);
        reg_write(tcps_pkg::REG_DEBOUNCE, 32'd0);
        reg_write(tcps_pkg::REG_CEILING, 32'hfff);
        words = 0;
        while (words < 40) begin
            n = $urandom_range(1, 8);
            capture(n);
            words += n + 2;
        end
        drain();
        reg_write(tcps_pkg::REG_THRESH, 32'hfff);
        reg_write(tcps_pkg::REG_DEBOUNCE, 32'hffff);
        reg_write(tcps_pkg::REG_CEILING, 32'd0);
        repeat (3) capture($urandom_range(1, 10));
        drain();
        reg_write(tcps_pkg::REG_THRESH, 32'd200 + $urandom_range(0, 3000));
        reg_write(tcps_pkg::REG_DEBOUNCE, $urandom_range(0, 600));
        reg_write(tcps_pkg::REG_CEILING, $urandom_range(1, 4095));
        words = 0;
        while (words < 90) begin
            if ($urandom_range(0, 7) == 0) begin
                // noise: stray words of any code
                send_word(2'($urandom()), 12'($urandom()), 12'($urandom()),
                          12'($urandom()), $urandom());
                words++;
            end else begin
                n = $urandom_range(1, 12);
                capture(n);
                words += n + 2;
            end
        end
        drain();
        reg_write(tcps_pkg::REG_THRESH, 32'(tcps_pkg::THRESH_RST));
        reg_write(tcps_pkg::REG_DEBOUNCE, 32'(tcps_pkg::DEBOUNCE_RST));
        reg_write(tcps_pkg::REG_CEILING, 32'(tcps_pkg::CEILING_RST));
        repeat (2) capture($urandom_range(1, 6));
        drain();

        if (stats_board.mismatches == 0 && stats_board.pending_stats.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
